>>> hw/rtl/ami_pkg.sv
// ----------------------------------------------------------------------------
// ami_pkg
// Shared widths, payload types, stage records and constants of the affine
// matrix inverse pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ami_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int PROD_W = 2 * DATA_WIDTH;
   localparam int COF_W  = 2 * DATA_WIDTH + 1;
   localparam int CMAG_W = 2 * DATA_WIDTH;
   localparam int DET_W  = 3 * DATA_WIDTH + 1;
   localparam int MAG_W  = 3 * DATA_WIDTH;
   localparam int DV_W   = 3 * DATA_WIDTH + 1;
   localparam int PP_W   = 2 * DATA_WIDTH + 1;
   localparam int NUM_A  = 2 * DATA_WIDTH + 2 * FRAC_BITS + 1;
   localparam int NUM_W  = ((NUM_A > MAG_W) ? NUM_A : MAG_W) + 1;
   localparam int REM_W  = (NUM_W > DV_W + DATA_WIDTH) ? NUM_W : DV_W + DATA_WIDTH;
   localparam int SUM_W  = 2 * DATA_WIDTH + 2;
   localparam int RND_W  = 2 * DATA_WIDTH + 1;

   typedef logic signed [DATA_WIDTH-1:0] elem_type;
   typedef elem_type [8:0]               elem9_type;
   typedef elem_type [2:0]               elem3_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [COF_W-1:0]      cof_type;
   typedef logic [CMAG_W-1:0]            cmag_type;
   typedef logic signed [DET_W-1:0]      det_type;
   typedef logic [MAG_W-1:0]             mag_type;
   typedef logic [DV_W-1:0]              dv_type;
   typedef logic signed [PP_W-1:0]       pp_type;
   typedef logic [NUM_W-1:0]             num_type;
   typedef logic [REM_W-1:0]             remx_type;
   typedef logic [DATA_WIDTH-1:0]        quo_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic [RND_W-1:0]             rnd_type;
   typedef logic [1:0]                   col_type;

   localparam col_type  COL_SHIFT = 2'd3;
   localparam elem_type MAX_VAL   = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
   localparam elem_type MIN_VAL   = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
   localparam elem_type ONE_VAL   = (FRAC_BITS >= DATA_WIDTH - 1) ? MAX_VAL :
                                    (elem_type'(1) << FRAC_BITS);

   typedef struct packed {
      elem_type lin_r0_c0;
      elem_type lin_r1_c0;
      elem_type lin_r2_c0;
      elem_type lin_r0_c1;
      elem_type lin_r1_c1;
      elem_type lin_r2_c1;
      elem_type lin_r0_c2;
      elem_type lin_r1_c2;
      elem_type lin_r2_c2;
      elem_type shift_x;
      elem_type shift_y;
      elem_type shift_z;
   } req_type;

   typedef struct packed {
      col_type  column_index;
      elem_type row0_value;
      elem_type row1_value;
      elem_type row2_value;
      logic     singular;
      logic     last_column;
   } rsp_type;

   typedef struct packed {
      logic            valid;
      cof_type [8:0]   cof;
      elem3_type       lrow;
      elem3_type       shift;
   } cof_out_type;

   typedef struct packed {
      logic            valid;
      det_type         det;
      cmag_type [8:0]  cmag;
      logic [8:0]      csign;
      elem3_type       shift;
   } det_out_type;

   typedef struct packed {
      logic            valid;
      logic            singular;
      elem9_type       res;
      elem3_type       shift;
   } lin_out_type;

   typedef struct packed {
      logic            valid;
      logic            singular;
      elem9_type       res;
      elem3_type       tr;
   } fin_type;

endpackage

>>> hw/rtl/ami_cofactor.sv
// ----------------------------------------------------------------------------
// ami_cofactor
// Input register, the eighteen 2x2 products and the nine exact cofactors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ami_cofactor (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  ami_pkg::req_type     in_data,
   output ami_pkg::cof_out_type cof_out
);
   import ami_pkg::*;

   // operand pairs of each cofactor, flat index row * 3 + col
   localparam int COF_SEL [9][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

   logic            lin_valid_ff, lin_valid_in;
   elem9_type       lin_ff, lin_in;
   elem3_type       shift_ff, shift_in;
   logic            prod_valid_ff, prod_valid_in;
   prod_type [17:0] prod_ff, prod_in;
   elem3_type       row_ff, row_in;
   elem3_type       pshift_ff, pshift_in;
   cof_out_type     cof_ff, cof_in;

   always_comb begin
      lin_valid_in = in_valid;
      lin_in[0] = in_data.lin_r0_c0;
      lin_in[1] = in_data.lin_r0_c1;
      lin_in[2] = in_data.lin_r0_c2;
      lin_in[3] = in_data.lin_r1_c0;
      lin_in[4] = in_data.lin_r1_c1;
      lin_in[5] = in_data.lin_r1_c2;
      lin_in[6] = in_data.lin_r2_c0;
      lin_in[7] = in_data.lin_r2_c1;
      lin_in[8] = in_data.lin_r2_c2;
      shift_in = {in_data.shift_z, in_data.shift_y, in_data.shift_x};

      prod_valid_in = lin_valid_ff;
      for (int m = 0; m < 9; m++) begin
         prod_in[2*m]   = $signed(lin_ff[COF_SEL[m][0]]) * $signed(lin_ff[COF_SEL[m][1]]);
         prod_in[2*m+1] = $signed(lin_ff[COF_SEL[m][2]]) * $signed(lin_ff[COF_SEL[m][3]]);
      end
      row_in    = lin_ff[2:0];
      pshift_in = shift_ff;

      cof_in.valid = prod_valid_ff;
      for (int m = 0; m < 9; m++) begin
         cof_in.cof[m] = COF_W'($signed(prod_ff[2*m])) - COF_W'($signed(prod_ff[2*m+1]));
      end
      cof_in.lrow  = row_ff;
      cof_in.shift = pshift_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         cof_ff.valid  <= 1'b0;
      end else if (en) begin
         lin_valid_ff  <= lin_valid_in;
         lin_ff        <= lin_in;
         shift_ff      <= shift_in;
         prod_valid_ff <= prod_valid_in;
         prod_ff       <= prod_in;
         row_ff        <= row_in;
         pshift_ff     <= pshift_in;
         cof_ff        <= cof_in;
      end
   end

   assign cof_out = cof_ff;

endmodule

>>> hw/rtl/ami_det.sv
// ----------------------------------------------------------------------------
// ami_det
// Determinant from row 0 and the first cofactor column, split into
// partial products, plus cofactor magnitudes and signs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ami_det (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  ami_pkg::cof_out_type cof_in,
   output ami_pkg::det_out_type det_out
);
   import ami_pkg::*;

   logic           pp_valid_ff, pp_valid_in;
   pp_type [2:0]   lo_ff, lo_in;
   pp_type [2:0]   hi_ff, hi_in;
   cmag_type [8:0] cmag_ff, cmag_in;
   logic [8:0]     csign_ff, csign_in;
   elem3_type      shift_ff, shift_in;
   cof_type [8:0]  cof_neg;
   det_out_type    det_ff, det_in;

   always_comb begin
      pp_valid_in = cof_in.valid;
      for (int j = 0; j < 3; j++) begin
         lo_in[j] = $signed(cof_in.lrow[j]) *
                    $signed({1'b0, cof_in.cof[3*j][DATA_WIDTH-1:0]});
         hi_in[j] = $signed(cof_in.lrow[j]) *
                    $signed(cof_in.cof[3*j][COF_W-1:DATA_WIDTH]);
      end
      for (int m = 0; m < 9; m++) begin
         cof_neg[m]  = -cof_in.cof[m];
         csign_in[m] = cof_in.cof[m][COF_W-1];
         cmag_in[m]  = csign_in[m] ? cof_neg[m][CMAG_W-1:0] : cof_in.cof[m][CMAG_W-1:0];
      end
      shift_in = cof_in.shift;

      det_in.valid = pp_valid_ff;
      det_in.det   = '0;
      for (int j = 0; j < 3; j++) begin
         det_in.det = det_in.det + (DET_W'($signed(hi_ff[j])) << DATA_WIDTH)
                                 + DET_W'($signed(lo_ff[j]));
      end
      det_in.cmag  = cmag_ff;
      det_in.csign = csign_ff;
      det_in.shift = shift_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff  <= 1'b0;
         det_ff.valid <= 1'b0;
      end else if (en) begin
         pp_valid_ff <= pp_valid_in;
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         cmag_ff     <= cmag_in;
         csign_ff    <= csign_in;
         shift_ff    <= shift_in;
         det_ff      <= det_in;
      end
   end

   assign det_out = det_ff;

endmodule

>>> hw/rtl/ami_divider.sv
// ----------------------------------------------------------------------------
// ami_divider
// Nine parallel restoring dividers, one quotient bit per stage, giving the
// rounded and saturated inverse linear part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ami_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  ami_pkg::det_out_type det_in,
   output ami_pkg::lin_out_type lin_out
);
   import ami_pkg::*;

   localparam int NSTAGE = DATA_WIDTH + 2;

   typedef struct packed {
      logic           valid;
      logic           singular;
      mag_type        ad;
      logic [8:0]     neg;
      cmag_type [8:0] cmag;
      elem3_type      shift;
   } prep_type;

   typedef struct packed {
      logic           valid;
      logic           singular;
      dv_type         dv;
      logic [8:0]     neg;
      logic [8:0]     ovf;
      num_type [8:0]  rem;
      quo_type [8:0]  quo;
      elem3_type      shift;
   } stage_type;

   prep_type    prep_ff, prep_in;
   det_type     det_neg;
   stage_type   stage_ff [NSTAGE];
   stage_type   stage_in [NSTAGE];
   lin_out_type lin_ff, lin_in;

   always_comb begin
      det_neg          = -det_in.det;
      prep_in.valid    = det_in.valid;
      prep_in.singular = (det_in.det == '0);
      prep_in.ad       = det_in.det[DET_W-1] ? det_neg[MAG_W-1:0] : det_in.det[MAG_W-1:0];
      prep_in.neg      = det_in.csign ^ {9{det_in.det[DET_W-1]}};
      prep_in.cmag     = det_in.cmag;
      prep_in.shift    = det_in.shift;
   end

   always_comb begin
      remx_type dsh;
      remx_type trial;
      logic     ge;
      dsh   = '0;
      trial = '0;
      ge    = 1'b0;
      stage_in[0].valid    = prep_ff.valid;
      stage_in[0].singular = prep_ff.singular;
      stage_in[0].dv       = {prep_ff.ad, 1'b0};
      stage_in[0].neg      = prep_ff.neg;
      stage_in[0].ovf      = '0;
      stage_in[0].quo      = '0;
      stage_in[0].shift    = prep_ff.shift;
      for (int m = 0; m < 9; m++) begin
         stage_in[0].rem[m] = (NUM_W'(prep_ff.cmag[m]) << (2 * FRAC_BITS + 1)) +
                              NUM_W'(prep_ff.ad);
      end
      for (int s = 1; s < NSTAGE; s++) begin
         stage_in[s] = stage_ff[s-1];
         for (int m = 0; m < 9; m++) begin
            if (s == 1) begin
               dsh = REM_W'(stage_ff[s-1].dv) << DATA_WIDTH;
               stage_in[s].ovf[m] = (REM_W'(stage_ff[s-1].rem[m]) >= dsh);
            end else begin
               dsh   = REM_W'(stage_ff[s-1].dv) << (DATA_WIDTH + 1 - s);
               trial = REM_W'(stage_ff[s-1].rem[m]) - dsh;
               ge    = (REM_W'(stage_ff[s-1].rem[m]) >= dsh);
               if (ge) begin
                  stage_in[s].rem[m] = trial[NUM_W-1:0];
               end
               stage_in[s].quo[m] = {stage_ff[s-1].quo[m][DATA_WIDTH-2:0], ge};
            end
         end
      end
   end

   always_comb begin
      quo_type q;
      lin_in.valid    = stage_ff[NSTAGE-1].valid;
      lin_in.singular = stage_ff[NSTAGE-1].singular;
      lin_in.shift    = stage_ff[NSTAGE-1].shift;
      for (int m = 0; m < 9; m++) begin
         q = stage_ff[NSTAGE-1].quo[m];
         if (!stage_ff[NSTAGE-1].neg[m]) begin
            if (stage_ff[NSTAGE-1].ovf[m] || q[DATA_WIDTH-1]) begin
               lin_in.res[m] = MAX_VAL;
            end else begin
               lin_in.res[m] = q;
            end
         end else begin
            if (stage_ff[NSTAGE-1].ovf[m] || (q[DATA_WIDTH-1] && (|q[DATA_WIDTH-2:0]))) begin
               lin_in.res[m] = MIN_VAL;
            end else begin
               lin_in.res[m] = -q;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
         for (int s = 0; s < NSTAGE; s++) begin
            stage_ff[s].valid <= 1'b0;
         end
         lin_ff.valid <= 1'b0;
      end else if (en) begin
         prep_ff <= prep_in;
         for (int s = 0; s < NSTAGE; s++) begin
            stage_ff[s] <= stage_in[s];
         end
         lin_ff <= lin_in;
      end
   end

   assign lin_out = lin_ff;

endmodule

>>> hw/rtl/ami_translate.sv
// ----------------------------------------------------------------------------
// ami_translate
// New translation: minus the inverse linear part times the old translation,
// rounded to the element format and saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ami_translate (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  ami_pkg::lin_out_type lin_in,
   output ami_pkg::fin_type     fin_out
);
   import ami_pkg::*;

   typedef struct packed {
      logic      valid;
      logic      singular;
      elem9_type res;
   } side_type;

   side_type        side1_ff, side1_in, side2_ff, side2_in, side3_ff, side3_in;
   prod_type [8:0]  prod_ff, prod_in;
   sum_type [2:0]   sum_ff, sum_in;
   sum_type [2:0]   sum_neg;
   cmag_type [2:0]  smag_ff, smag_in;
   logic [2:0]      ssign_ff, ssign_in;
   rnd_type [2:0]   rnd;
   fin_type         fin_ff, fin_in;

   always_comb begin
      side1_in.valid    = lin_in.valid;
      side1_in.singular = lin_in.singular;
      side1_in.res      = lin_in.res;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r*3+c] = $signed(lin_in.shift[c]) * $signed(lin_in.res[r*3+c]);
         end
      end

      side2_in = side1_ff;
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = SUM_W'($signed(prod_ff[r*3])) + SUM_W'($signed(prod_ff[r*3+1])) +
                     SUM_W'($signed(prod_ff[r*3+2]));
      end

      side3_in = side2_ff;
      for (int r = 0; r < 3; r++) begin
         sum_neg[r]  = -sum_ff[r];
         ssign_in[r] = sum_ff[r][SUM_W-1];
         smag_in[r]  = ssign_in[r] ? sum_neg[r][CMAG_W-1:0] : sum_ff[r][CMAG_W-1:0];
      end

      fin_in.valid    = side3_ff.valid;
      fin_in.singular = side3_ff.singular;
      fin_in.res      = side3_ff.res;
      for (int r = 0; r < 3; r++) begin
         rnd[r] = (RND_W'(smag_ff[r]) + (RND_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
         if (ssign_ff[r]) begin
            if (rnd[r] > RND_W'(MAX_VAL)) begin
               fin_in.tr[r] = MAX_VAL;
            end else begin
               fin_in.tr[r] = rnd[r][DATA_WIDTH-1:0];
            end
         end else begin
            if (rnd[r] > (RND_W'(1) << (DATA_WIDTH - 1))) begin
               fin_in.tr[r] = MIN_VAL;
            end else begin
               fin_in.tr[r] = -rnd[r][DATA_WIDTH-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff.valid <= 1'b0;
         side2_ff.valid <= 1'b0;
         side3_ff.valid <= 1'b0;
         fin_ff.valid   <= 1'b0;
      end else if (en) begin
         side1_ff <= side1_in;
         prod_ff  <= prod_in;
         side2_ff <= side2_in;
         sum_ff   <= sum_in;
         side3_ff <= side3_in;
         smag_ff  <= smag_in;
         ssign_ff <= ssign_in;
         fin_ff   <= fin_in;
      end
   end

   assign fin_out = fin_ff;

endmodule

>>> hw/rtl/ami_output.sv
// ----------------------------------------------------------------------------
// ami_output
// Result holding register that sends the four inverse columns in turn and
// sets the pipeline advance enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ami_output (
   input  logic              clock,
   input  logic              reset,
   input  ami_pkg::fin_type  fin_in,
   output logic              en,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ami_pkg::rsp_type  rsp_data
);
   import ami_pkg::*;

   logic      hold_valid_ff, hold_valid_in;
   col_type   col_ff, col_in;
   fin_type   hold_ff;
   elem3_type rows;

   assign en        = !hold_valid_ff || (rsp_ready && (col_ff == COL_SHIFT));
   assign rsp_valid = hold_valid_ff;

   always_comb begin
      if (en) begin
         hold_valid_in = fin_in.valid;
         col_in        = '0;
      end else begin
         hold_valid_in = hold_valid_ff;
         col_in        = rsp_ready ? col_ff + 2'd1 : col_ff;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         if (hold_ff.singular) begin
            rows[r] = (col_ff == 2'(r)) ? ONE_VAL : '0;
         end else begin
            case (col_ff)
               2'd0:    rows[r] = hold_ff.res[r*3];
               2'd1:    rows[r] = hold_ff.res[r*3+1];
               2'd2:    rows[r] = hold_ff.res[r*3+2];
               default: rows[r] = hold_ff.tr[r];
            endcase
         end
      end
      rsp_data.column_index = col_ff;
      rsp_data.row0_value   = rows[0];
      rsp_data.row1_value   = rows[1];
      rsp_data.row2_value   = rows[2];
      rsp_data.singular     = hold_ff.singular;
      rsp_data.last_column  = (col_ff == COL_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         col_ff        <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         col_ff        <= col_in;
         if (en) begin
            hold_ff <= fin_in;
         end
      end
   end

endmodule

>>> hw/rtl/affine_matrix_inverse_unit.sv
// ----------------------------------------------------------------------------
// affine_matrix_inverse_unit
// Path: a request passes the cofactor, determinant, divider and translation
// stages into the result register, which sends its four columns in turn.
// Flow: set by the four column transfers on the single result port; the
// whole pipeline advances on one enable, held until the last column moves.
// Reset: synchronous, clears every stage valid bit and the column counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module affine_matrix_inverse_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ami_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ami_pkg::rsp_type rsp_data
);
   import ami_pkg::*;

   logic        en;
   cof_out_type cof_bus;
   det_out_type det_bus;
   lin_out_type lin_bus;
   fin_type     fin_bus;

   assign req_ready = en;

   ami_cofactor u_cofactor (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_data  (req_data),
      .cof_out  (cof_bus)
   );

   ami_det u_det (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .cof_in  (cof_bus),
      .det_out (det_bus)
   );

   ami_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .det_in  (det_bus),
      .lin_out (lin_bus)
   );

   ami_translate u_translate (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .lin_in  (lin_bus),
      .fin_out (fin_bus)
   );

   ami_output u_output (
      .clock     (clock),
      .reset     (reset),
      .fin_in    (fin_bus),
      .en        (en),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/ami_checker.sv
// ----------------------------------------------------------------------------
// ami_checker
// Port level checks of the column sequence and request flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ami_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ami_pkg::rsp_type rsp_data
);
   import ami_pkg::*;

   // last flag marks the translation column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_column == (rsp_data.column_index == COL_SHIFT)))
      else $error("last_column does not match column index");

   // columns of one matrix follow each other
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_column |=>
         rsp_valid && (rsp_data.column_index == $past(rsp_data.column_index) + 2'd1) &&
         (rsp_data.singular == $past(rsp_data.singular)))
      else $error("column sequence broken");

   // a new request can be taken when the last column transfers
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_column |-> req_ready)
      else $error("request stalled on last column transfer");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind affine_matrix_inverse_unit ami_checker u_ami_checker (.*);

>>> sim/affine_matrix_inverse_unit_tb.sv
// ----------------------------------------------------------------------------
// affine_matrix_inverse_unit_tb
// Sends affine matrices through the inverse unit with random gaps on both
// sides, predicts the four column results of each matrix with exact wide
// arithmetic and checks every column transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module affine_matrix_inverse_unit_tb;
   import ami_pkg::*;

   typedef logic signed [255:0] wide_type;
   typedef logic [255:0]        uwide_type;

   class inverse_scoreboard;
      rsp_type column_q[$];
      int      errors = 0;

      function wide_type clamp(wide_type v);
         if (v > wide_type'(MAX_VAL)) return wide_type'(MAX_VAL);
         if (v < wide_type'(MIN_VAL)) return wide_type'(MIN_VAL);
         return v;
      endfunction

      function wide_type divide_round(wide_type c, wide_type d);
         uwide_type ad, num, q;
         ad  = (d < 0) ? uwide_type'(-d) : uwide_type'(d);
         num = ((c < 0) ? uwide_type'(-c) : uwide_type'(c)) << (2 * FRAC_BITS);
         q   = ((num << 1) + ad) / (ad << 1);
         if ((c < 0) != (d < 0)) return clamp(-wide_type'(q));
         return clamp(wide_type'(q));
      endfunction

      function void note_request(req_type m);
         wide_type l[3][3];
         wide_type t[3];
         wide_type cf[3][3];
         wide_type res[4][3];
         wide_type det, s, mag;
         rsp_type  col;
         l[0][0] = m.lin_r0_c0; l[1][0] = m.lin_r1_c0; l[2][0] = m.lin_r2_c0;
         l[0][1] = m.lin_r0_c1; l[1][1] = m.lin_r1_c1; l[2][1] = m.lin_r2_c1;
         l[0][2] = m.lin_r0_c2; l[1][2] = m.lin_r1_c2; l[2][2] = m.lin_r2_c2;
         t[0] = m.shift_x; t[1] = m.shift_y; t[2] = m.shift_z;
         cf[0][0] = l[1][1] * l[2][2] - l[1][2] * l[2][1];
         cf[1][0] = l[1][2] * l[2][0] - l[1][0] * l[2][2];
         cf[2][0] = l[1][0] * l[2][1] - l[1][1] * l[2][0];
         cf[0][1] = l[0][2] * l[2][1] - l[0][1] * l[2][2];
         cf[1][1] = l[0][0] * l[2][2] - l[0][2] * l[2][0];
         cf[2][1] = l[0][1] * l[2][0] - l[0][0] * l[2][1];
         cf[0][2] = l[0][1] * l[1][2] - l[0][2] * l[1][1];
         cf[1][2] = l[0][2] * l[1][0] - l[0][0] * l[1][2];
         cf[2][2] = l[0][0] * l[1][1] - l[0][1] * l[1][0];
         det = l[0][0] * cf[0][0] + l[0][1] * cf[1][0] + l[0][2] * cf[2][0];
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 3; r++)
               res[c][r] = (det == 0 && r == c) ? wide_type'(ONE_VAL) : 0;
         if (det != 0) begin
            for (int c = 0; c < 3; c++)
               for (int r = 0; r < 3; r++)
                  res[c][r] = divide_round(cf[r][c], det);
            for (int r = 0; r < 3; r++) begin
               s   = t[0] * res[0][r] + t[1] * res[1][r] + t[2] * res[2][r];
               mag = (((s < 0) ? -s : s) + (wide_type'(1) << (FRAC_BITS - 1)))
                     >>> FRAC_BITS;
               res[3][r] = clamp((s < 0) ? mag : -mag);
            end
         end
         for (int c = 0; c < 4; c++) begin
            col.column_index = col_type'(c);
            col.row0_value   = elem_type'(res[c][0]);
            col.row1_value   = elem_type'(res[c][1]);
            col.row2_value   = elem_type'(res[c][2]);
            col.singular     = (det == 0);
            col.last_column  = (c == 3);
            column_q.push_back(col);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         if (column_q.size() == 0) begin
            $error("unexpected column transfer %p", got);
            errors++;
            return;
         end
         exp = column_q.pop_front();
         if (got.column_index !== exp.column_index) begin
            $error("column_index exp %0d got %0d", exp.column_index, got.column_index);
            errors++;
         end
         if (got.row0_value !== exp.row0_value) begin
            $error("row0_value exp %h got %h", exp.row0_value, got.row0_value);
            errors++;
         end
         if (got.row1_value !== exp.row1_value) begin
            $error("row1_value exp %h got %h", exp.row1_value, got.row1_value);
            errors++;
         end
         if (got.row2_value !== exp.row2_value) begin
            $error("row2_value exp %h got %h", exp.row2_value, got.row2_value);
            errors++;
         end
         if (got.singular !== exp.singular) begin
            $error("singular exp %0b got %0b", exp.singular, got.singular);
            errors++;
         end
         if (got.last_column !== exp.last_column) begin
            $error("last_column exp %0b got %0b", exp.last_column, got.last_column);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;

   inverse_scoreboard board = new();
   bit  no_idle = 0;
   int  hold_asks = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  cycles = 0;

   affine_matrix_inverse_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 300000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver side, with a long hold-off when the test asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= 400;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 31);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   task automatic send_matrix(req_type m);
      req_valid <= 1;
      req_data  <= m;
      do @(posedge clock); while (!req_ready);
      if (!no_idle && $urandom_range(99) < 31) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic elem_type pick_elem(int mode);
      case (mode)
         0:       return elem_type'($urandom);
         1:       return elem_type'($urandom_range(0, 32'h80000)) - elem_type'(32'h40000);
         default: return elem_type'($urandom_range(0, 32'h400)) - elem_type'(32'h200);
      endcase
   endfunction

   function automatic req_type random_matrix();
      req_type m;
      int      mode;
      mode = $urandom_range(9);
      mode = (mode < 2) ? 0 : (mode < 8) ? 1 : 2;
      m = {pick_elem(mode), pick_elem(mode), pick_elem(mode), pick_elem(mode),
           pick_elem(mode), pick_elem(mode), pick_elem(mode), pick_elem(mode),
           pick_elem(mode), pick_elem($urandom_range(1)), pick_elem($urandom_range(1)),
           pick_elem($urandom_range(1))};
      if ($urandom_range(9) == 0) begin
         m.lin_r0_c2 = m.lin_r0_c0;
         m.lin_r1_c2 = m.lin_r1_c0;
         m.lin_r2_c2 = m.lin_r2_c0;
      end
      return m;
   endfunction

   function automatic req_type diag_matrix(elem_type d, elem_type s);
      req_type m;
      m = '0;
      m.lin_r0_c0 = d; m.lin_r1_c1 = d; m.lin_r2_c2 = d;
      m.shift_x = s; m.shift_y = -s; m.shift_z = s;
      return m;
   endfunction

   initial begin
      req_type m;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed cases
      send_matrix(diag_matrix(ONE_VAL, ONE_VAL));
      send_matrix('0);
      send_matrix({12{MAX_VAL}});
      send_matrix({12{MIN_VAL}});
      send_matrix(diag_matrix(elem_type'(1), MAX_VAL));
      send_matrix(diag_matrix(MIN_VAL, MIN_VAL));
      send_matrix(diag_matrix(MAX_VAL, MAX_VAL));
      send_matrix(diag_matrix(-ONE_VAL, elem_type'(3)));
      send_matrix(diag_matrix(elem_type'(3 * ONE_VAL), elem_type'(1)));
      send_matrix({MAX_VAL, MIN_VAL, MAX_VAL, MIN_VAL, MAX_VAL, MIN_VAL,
                   MIN_VAL, MAX_VAL, MAX_VAL, MAX_VAL, MIN_VAL, MAX_VAL});
      m = diag_matrix(elem_type'(2), MIN_VAL);
      m.lin_r0_c1 = elem_type'(1);
      send_matrix(m);
      m = diag_matrix(ONE_VAL, ONE_VAL);
      m.lin_r1_c1 = '0;
      send_matrix(m);
      send_matrix({12{elem_type'(-1)}});

      // random with idling
      repeat (100) send_matrix(random_matrix());
      // stretch with no idling at all
      no_idle = 1;
      repeat (60) send_matrix(random_matrix());
      no_idle = 0;
      // receiver holds off so the pipeline fills and backs up
      hold_asks = hold_asks + 1;
      repeat (40) send_matrix(random_matrix());
      // sender pauses until the pipeline drains
      req_valid <= 0;
      @(posedge clock);
      while (board.column_q.size() != 0) @(posedge clock);
      repeat (60) send_matrix(random_matrix());
      req_valid <= 0;
      @(posedge clock);

      while (board.column_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> affine_matrix_inverse_unit.f
hw/rtl/ami_pkg.sv
hw/rtl/ami_cofactor.sv
hw/rtl/ami_det.sv
hw/rtl/ami_divider.sv
hw/rtl/ami_translate.sv
hw/rtl/ami_output.sv
hw/rtl/affine_matrix_inverse_unit.sv
hw/rtl/ami_checker.sv
sim/affine_matrix_inverse_unit_tb.sv
